FILE: rtl/core/mhic_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhic_pkg
// Shared types and constants of the hard-iron calibrator.
// ---------------------------------------------------------------------------
package mhic_pkg;

  localparam int AXES_MAX     = 3;
  localparam int AXES_DEFAULT = 3;

  localparam int SAMPLE_W = 16;
  localparam int CORR_W   = 17;
  localparam int TIME_W   = 32;

  localparam logic [TIME_W-1:0] CAL_WINDOW_RESET = TIME_W'(30000000);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_START  = 1'b1
  } op_t;

  typedef struct packed {
    logic sample;
    logic start;
    logic track;
    logic finish;
  } cal_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/magnetometer_hard_iron_calibrator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// magnetometer_hard_iron_calibrator
// Min/max hard-iron offset calibration of a three-axis magnetometer stream.
//
// Input stream: s_axis_tuser selects a sample or a start-calibration command,
// s_axis_tdata carries the microsecond timestamp and the three raw axes.
// Output stream: one result per input item with the corrected axes in
// m_axis_tdata and the calibrating and healthy flags in m_axis_tuser.
// Configuration: cfg_wr_en writes cfg_wr_data to the window length in
// microseconds; write it only while no item is in flight.
// The item passes from the input register to the result register, which
// drives m_axis_tvalid; it moves on only while the result register is
// free or being read. Throughput is one item per cycle while the receiver
// takes every result; the offset, min/max and window state is updated
// in the same cycle that moves an item from the input to the result
// register, so the next item sees it at once.
// Reset clears all offsets, min/max and last values to zero, stops
// calibration and sets the window to 30000000 us. When the receiver stalls
// the result register holds, the input register still takes one item, and
// s_axis_tready falls only when both are full.
// ---------------------------------------------------------------------------
module magnetometer_hard_iron_calibrator
  import mhic_pkg::*;
#(
  parameter int AXES = AXES_DEFAULT
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] time_us, [47:32] sample_x, [63:48] sample_y, [79:64] sample_z
  input  wire logic [79:0]       s_axis_tdata,
  // [0] op
  input  wire logic              s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [16:0] corr_x, [33:17] corr_y, [50:34] corr_z, [55:51] zero
  output logic [55:0]            m_axis_tdata,
  // [0] calibrating, [1] healthy
  output logic [1:0]             m_axis_tuser,
  input  wire logic              cfg_wr_en,
  input  wire logic [TIME_W-1:0] cfg_wr_data
);

  logic                       in_valid;
  op_t                        in_op;
  logic [TIME_W-1:0]          in_time;
  logic signed [SAMPLE_W-1:0] in_sample [AXES_MAX];
  logic                       advance;
  logic                       fire;
  cal_ctrl_t                  ctrl;
  logic                       calibrating;
  logic signed [CORR_W-1:0]   corr [AXES_MAX];
  logic [AXES_MAX-1:0]        axis_ok;
  logic                       healthy;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op        <= op_t'(s_axis_tuser);
      in_time      <= s_axis_tdata[31:0];
      in_sample[0] <= s_axis_tdata[47:32];
      in_sample[1] <= s_axis_tdata[63:48];
      in_sample[2] <= s_axis_tdata[79:64];
    end
  end

  mhic_timer u_timer (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .op          (in_op),
    .time_us     (in_time),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctrl        (ctrl),
    .calibrating (calibrating)
  );

  for (genvar a = 0; a < AXES_MAX; a++) begin : g_axis
    if (a < AXES) begin : g_used
      mhic_axis u_axis (
        .clk    (clk),
        .rst    (rst),
        .fire   (fire),
        .ctrl   (ctrl),
        .sample (in_sample[a]),
        .corr   (corr[a])
      );
      assign axis_ok[a] = (corr[a] != '0);
    end else begin : g_unused
      assign corr[a]    = '0;
      assign axis_ok[a] = 1'b1;
    end
  end

  assign healthy = &axis_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {5'b0, corr[2], corr[1], corr[0]};
      m_axis_tuser <= {healthy, calibrating};
    end
  end

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_axis_tvalid)
    else $error("processed item produced no result");

  a_ready_when_output_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("pending item dropped during stall");

endmodule
`default_nettype wire

FILE: rtl/core/mhic_timer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhic_timer
// Calibration window control: window register, start time, active flag and
// per-item decode of start, track and finish.
// ---------------------------------------------------------------------------
module mhic_timer
  import mhic_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire op_t               op,
  input  wire logic [TIME_W-1:0] time_us,
  input  wire logic              cfg_wr_en,
  input  wire logic [TIME_W-1:0] cfg_wr_data,
  output cal_ctrl_t              ctrl,
  output logic                   calibrating
);

  logic [TIME_W-1:0] cal_window;
  logic [TIME_W-1:0] cal_start;
  logic              cal_active;
  logic [TIME_W-1:0] elapsed;
  logic              in_window;

  always_comb begin
    elapsed     = time_us - cal_start;
    in_window   = elapsed < cal_window;
    ctrl.start  = (op == OP_START);
    ctrl.sample = (op == OP_SAMPLE);
    ctrl.track  = ctrl.sample && cal_active && in_window;
    ctrl.finish = ctrl.sample && cal_active && !in_window;
    calibrating = ctrl.start || ctrl.track;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_window <= CAL_WINDOW_RESET;
    end else if (cfg_wr_en) begin
      cal_window <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_active <= 1'b0;
      cal_start  <= '0;
    end else if (fire) begin
      cal_active <= calibrating;
      if (ctrl.start) begin
        cal_start <= time_us;
      end
    end
  end

  a_start_sets_active: assert property (@(posedge clk) disable iff (rst)
    fire && ctrl.start |=> cal_active)
    else $error("calibration not active after start");

  a_finish_clears_active: assert property (@(posedge clk) disable iff (rst)
    fire && ctrl.finish |=> !cal_active)
    else $error("calibration still active after window end");

  a_track_needs_active: assert property (@(posedge clk) disable iff (rst)
    ctrl.track || ctrl.finish |-> cal_active)
    else $error("tracking or finishing while calibration idle");

endmodule
`default_nettype wire

FILE: rtl/core/mhic_axis.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhic_axis
// One axis: offset subtraction, min/max tracking and offset computation.
// ---------------------------------------------------------------------------
module mhic_axis
  import mhic_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       fire,
  input  wire cal_ctrl_t                  ctrl,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic signed [CORR_W-1:0]        corr
);

  localparam logic signed [CORR_W:0] SAT_HI = (CORR_W+1)'((1 << (SAMPLE_W-1)) - 1);
  localparam logic signed [CORR_W:0] SAT_LO = ~SAT_HI;

  logic signed [SAMPLE_W-1:0] offset;
  logic signed [SAMPLE_W-1:0] offset_next;
  logic signed [CORR_W-1:0]   axis_min;
  logic signed [CORR_W-1:0]   axis_max;
  logic signed [CORR_W-1:0]   last_corr;
  logic signed [CORR_W-1:0]   corr_new;
  logic signed [CORR_W:0]     span_sum;
  logic signed [CORR_W:0]     round_sum;
  logic signed [CORR_W:0]     half;

  always_comb begin
    corr_new  = CORR_W'(sample) - CORR_W'(offset);
    corr      = ctrl.sample ? corr_new : last_corr;
    span_sum  = (CORR_W+1)'(axis_min) + (CORR_W+1)'(axis_max);
    round_sum = span_sum + (CORR_W+1)'(span_sum[CORR_W]);
    half      = round_sum >>> 1;
    if (half > SAT_HI) begin
      offset_next = SAMPLE_W'(SAT_HI);
    end else if (half < SAT_LO) begin
      offset_next = SAMPLE_W'(SAT_LO);
    end else begin
      offset_next = SAMPLE_W'(half);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= '0;
      axis_min  <= '0;
      axis_max  <= '0;
      last_corr <= '0;
    end else if (fire) begin
      if (ctrl.start) begin
        offset   <= '0;
        axis_min <= last_corr;
        axis_max <= last_corr;
      end else begin
        last_corr <= corr_new;
        if (ctrl.track) begin
          if (corr_new < axis_min) begin
            axis_min <= corr_new;
          end
          if (corr_new > axis_max) begin
            axis_max <= corr_new;
          end
        end
        if (ctrl.finish) begin
          offset <= offset_next;
        end
      end
    end
  end

  a_min_not_above_max: assert property (@(posedge clk) disable iff (rst)
    axis_min <= axis_max)
    else $error("axis minimum above maximum");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// Hard-iron calibrator testbench
// Streams magnetometer samples and start-calibration commands into the
// calibrator and compares every result with a cycle-free predictor of the
// offset subtraction, the min/max tracking and the end-of-window offset
// update. Directed cases cover saturation, truncation, restarts and window
// extremes with timestamp wrap. Random calibration runs follow, with random
// gaps on the input and random stalls on the output.
// ---------------------------------------------------------------------------
module testbench;
  import mhic_pkg::*;

  typedef struct packed {
    logic signed [CORR_W-1:0] corr_x;
    logic signed [CORR_W-1:0] corr_y;
    logic signed [CORR_W-1:0] corr_z;
    logic                     calibrating;
    logic                     healthy;
  } corr_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // [31:0] time_us, [47:32] sample_x, [63:48] sample_y, [79:64] sample_z
  logic [79:0]       s_axis_tdata = '0;
  // [0] op
  logic              s_axis_tuser = OP_SAMPLE;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [16:0] corr_x, [33:17] corr_y, [50:34] corr_z, [55:51] zero
  logic [55:0]       m_axis_tdata;
  // [0] calibrating, [1] healthy
  logic [1:0]        m_axis_tuser;
  logic              cfg_wr_en = 1'b0;
  logic [TIME_W-1:0] cfg_wr_data = '0;

  // predictor state
  logic [TIME_W-1:0] cal_window;
  int                hard_offset [3];
  int                trk_min [3];
  int                trk_max [3];
  int                last_corr [3];
  logic [TIME_W-1:0] cal_t0;
  bit                cal_on;

  corr_result_t      expected_corr_q [$];
  corr_result_t      exp_r;
  bit                idle_on = 1'b0;
  int                rx_stall = 0;
  int                errors = 0;
  int                items_sent = 0;
  int                samples_sent = 0;
  int                starts_sent = 0;
  int                cals_done = 0;
  int                windows_set = 0;
  int                results_seen = 0;

  magnetometer_hard_iron_calibrator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("Timeout: results still outstanding");
    $display("Test completed with failures");
    $finish;
  end

  function automatic corr_result_t correct_and_track(op_t op, logic [TIME_W-1:0] now,
                                                      logic signed [15:0] sx,
                                                      logic signed [15:0] sy,
                                                      logic signed [15:0] sz);
    corr_result_t res;
    int raw [3];
    int vals [3];
    int mid;
    bit ok;
    logic [TIME_W-1:0] elapsed;
    raw[0] = sx;
    raw[1] = sy;
    raw[2] = sz;
    if (op == OP_START) begin
      for (int a = 0; a < 3; a++) begin
        hard_offset[a] = 0;
        trk_min[a] = last_corr[a];
        trk_max[a] = last_corr[a];
      end
      cal_t0 = now;
      cal_on = 1'b1;
    end else begin
      for (int a = 0; a < 3; a++)
        last_corr[a] = (a < AXES_DEFAULT) ? raw[a] - hard_offset[a] : 0;
      if (cal_on) begin
        elapsed = now - cal_t0;
        if (elapsed < cal_window) begin
          for (int a = 0; a < AXES_DEFAULT; a++) begin
            if (last_corr[a] < trk_min[a]) trk_min[a] = last_corr[a];
            if (last_corr[a] > trk_max[a]) trk_max[a] = last_corr[a];
          end
        end else begin
          cal_on = 1'b0;
          cals_done++;
          for (int a = 0; a < 3; a++) begin
            mid = (trk_min[a] + trk_max[a]) / 2;
            if (mid > 32767) mid = 32767;
            else if (mid < -32768) mid = -32768;
            hard_offset[a] = (a < AXES_DEFAULT) ? mid : 0;
          end
        end
      end
    end
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      vals[a] = (a < AXES_DEFAULT) ? last_corr[a] : 0;
      if (a < AXES_DEFAULT && vals[a] == 0) ok = 1'b0;
    end
    res.corr_x = CORR_W'(vals[0]);
    res.corr_y = CORR_W'(vals[1]);
    res.corr_z = CORR_W'(vals[2]);
    res.calibrating = cal_on;
    res.healthy = ok;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [15:0] rand_axis();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom);
    if (r < 8) return 16'($urandom_range(0, 400) - 200);
    case ($urandom_range(0, 2))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'sh0000;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v)
      report_mismatch($sformatf("%s expected %0d, got %0d", name, exp_v, got_v));
  endtask

  // check each result transfer and drive receiver stalls
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_corr_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        exp_r = expected_corr_q.pop_front();
        results_seen++;
        check_field("corr_x", exp_r.corr_x, $signed(m_axis_tdata[16:0]));
        check_field("corr_y", exp_r.corr_y, $signed(m_axis_tdata[33:17]));
        check_field("corr_z", exp_r.corr_z, $signed(m_axis_tdata[50:34]));
        check_field("calibrating", exp_r.calibrating, m_axis_tuser[0]);
        check_field("healthy", exp_r.healthy, m_axis_tuser[1]);
      end
    end
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          m_axis_tready <= 1'b0;
          rx_stall <= $urandom_range(0, 2);
        end
        2: begin
          if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            rx_stall <= $urandom_range(8, 30);
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  task automatic send_item(op_t op, logic [TIME_W-1:0] now, logic signed [15:0] sx,
                           logic signed [15:0] sy, logic signed [15:0] sz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {sz, sy, sx, now};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_corr_q.push_back(correct_and_track(op, now, sx, sy, sz));
    items_sent++;
    if (op == OP_START) starts_sent++;
    else samples_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_corr_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(logic [TIME_W-1:0] w);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cal_window = w;
    windows_set++;
  endtask

  task automatic test_uncalibrated_passthrough();
    idle_on = 1'b0;
    send_item(OP_SAMPLE, 32'h0000_0000, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 32'hffff_ffff, 16'sh7fff, 16'sh8000, 16'sd1);
    send_item(OP_SAMPLE, 32'h5555_5555, -16'sd1, 16'sd0, 16'sh7fff);
    send_item(OP_SAMPLE, 32'haaaa_aaaa, 16'sh5555, 16'shaaaa, -16'sd1);
  endtask

  task automatic test_offset_saturation();
    idle_on = 1'b1;
    write_window(32'd1000);
    send_item(OP_SAMPLE, 32'd100, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_item(OP_START, 32'd200, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 32'd300, 16'sh7fff, 16'sh8000, 16'sd1);
    // elapsed equal to the window ends calibration
    send_item(OP_SAMPLE, 32'd1200, 16'sd5, 16'sd5, 16'sd5);
    send_item(OP_SAMPLE, 32'd5, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_item(OP_START, 32'd10, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 32'd2000, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 32'd2001, 16'sh7fff, 16'sh8000, 16'sh7fff);
  endtask

  task automatic test_restart_and_truncation();
    idle_on = 1'b1;
    send_item(OP_START, 32'd50, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 32'd60, -16'sd3, -16'sd5, 16'sd7);
    // restart while calibrating
    send_item(OP_START, 32'd70, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 32'd80, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 32'd1070, 16'sd9, 16'sd9, 16'sd9);
    // odd negative sums truncate toward zero
    send_item(OP_SAMPLE, 32'd1100, -16'sd1, -16'sd2, 16'sd3);
  endtask

  task automatic test_window_extremes();
    idle_on = 1'b0;
    write_window(32'd1);
    send_item(OP_START, 32'd500, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 32'd500, 16'sd11, -16'sd12, 16'sd13);
    send_item(OP_SAMPLE, 32'd501, 16'sd1, 16'sd1, 16'sd1);
    write_window(32'hffff_ffff);
    send_item(OP_START, 32'hffff_fff0, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 32'h0000_0010, 16'sd100, -16'sd100, 16'sd40);
    send_item(OP_SAMPLE, 32'hffff_ffee, -16'sd60, 16'sd20, 16'sd2);
    send_item(OP_SAMPLE, 32'hffff_ffef, 16'sd1, 16'sd1, 16'sd1);
  endtask

  task automatic test_random_calibration();
    logic [TIME_W-1:0] w;
    logic [TIME_W-1:0] t0;
    longint unsigned   span;
    int                n;
    while (items_sent < 530) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: w = 32'd1;
        1: w = 32'hffff_ffff;
        2: w = $urandom | 32'd1;
        3, 4, 5: w = $urandom_range(2, 64);
        default: w = $urandom_range(100, 5000);
      endcase
      write_window(w);
      repeat ($urandom_range(2, 6)) begin
        repeat ($urandom_range(0, 2))
          send_item(OP_SAMPLE, $urandom, rand_axis(), rand_axis(), rand_axis());
        t0 = $urandom;
        send_item(OP_START, t0, rand_axis(), rand_axis(), rand_axis());
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            t0 = $urandom;
            send_item(OP_START, t0, rand_axis(), rand_axis(), rand_axis());
          end else begin
            send_item(OP_SAMPLE, t0 + ($urandom % w), rand_axis(), rand_axis(), rand_axis());
          end
        end
        if ($urandom_range(0, 6) != 0) begin
          span = 64'h1_0000_0000 - w;
          send_item(OP_SAMPLE, t0 + w + 32'($urandom % span),
                    rand_axis(), rand_axis(), rand_axis());
        end
        repeat ($urandom_range(1, 3))
          send_item(OP_SAMPLE, $urandom, rand_axis(), rand_axis(), rand_axis());
      end
    end
  endtask

  initial begin
    cal_window = CAL_WINDOW_RESET;
    cal_t0 = '0;
    cal_on = 1'b0;
    for (int a = 0; a < 3; a++) begin
      hard_offset[a] = 0;
      trk_min[a] = 0;
      trk_max[a] = 0;
      last_corr[a] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_uncalibrated_passthrough();
    test_offset_saturation();
    test_restart_and_truncation();
    test_window_extremes();
    test_random_calibration();
    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d samples and %0d calibration starts across %0d window settings.",
             samples_sent, starts_sent, windows_set);
    $display("%0d calibrations ran to completion; %0d results checked.",
             cals_done, results_seen);
    if (errors == 0 && expected_corr_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
